// ===== rtl/kaa_pkg.sv =====
`default_nettype none

package kaa_pkg;

    // Field and register widths
    localparam int SETTLE_W   = 16;
    localparam int COUNT_W    = 8;
    localparam int STAGE_W    = 3;
    localparam int PACKED_W   = 40;
    localparam int PACKED_NUM = PACKED_W / COUNT_W;
    localparam int CFG_IDX_W  = 2;

    localparam int DEFAULT_NUM_STAGES = 5;

    // Reset values of the configuration registers
    localparam logic [SETTLE_W-1:0] SETTLE_THRESHOLD_RST = 16'd10;
    localparam logic [SETTLE_W-1:0] SETTLE_LIMIT_RST     = 16'd1000;
    localparam logic [PACKED_W-1:0] STAGE_WAIT_RST       = 40'h00_0104_0F00;
    localparam logic [PACKED_W-1:0] STAGE_REPEAT_RST     = 40'h00_0F0F_0101;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETTLE_THRESHOLD = 2'd0,
        REG_SETTLE_LIMIT     = 2'd1,
        REG_STAGE_WAIT       = 2'd2,
        REG_STAGE_REPEAT     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [SETTLE_W-1:0] settle_threshold;
        logic [SETTLE_W-1:0] settle_limit;
        logic [PACKED_W-1:0] stage_wait_times;
        logic [PACKED_W-1:0] stage_repeat_counts;
    } cfg_t;

    typedef struct packed {
        logic               press_event;
        logic [STAGE_W-1:0] repeat_stage;
    } result_t;

    // Pick byte of a packed stage register; stages above the register read zero
    function automatic logic [COUNT_W-1:0] stage_byte(
        input logic [PACKED_W-1:0] packed_bytes,
        input logic [STAGE_W-1:0]  stage
    );
        logic [COUNT_W-1:0] sel;
        sel = '0;
        for (int i = 0; i < PACKED_NUM; i++)
        begin
            if (stage == STAGE_W'(i))
            begin
                sel = packed_bytes[i*COUNT_W +: COUNT_W];
            end
        end
        return sel;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kaa_core.sv =====
`default_nettype none

module kaa_core
    import kaa_pkg::*;
#(
    parameter int NUM_STAGES = DEFAULT_NUM_STAGES
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire logic    level,
    input  wire cfg_t    cfg,
    output result_t      result
);

    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(NUM_STAGES - 1);

    logic                previous_level_reg, previous_level_next;
    logic [SETTLE_W-1:0] settle_count_reg,   settle_count_next;
    logic [COUNT_W-1:0]  wait_count_reg,     wait_count_next;
    logic [STAGE_W-1:0]  stage_index_reg,    stage_index_next;
    logic [COUNT_W-1:0]  stage_repeats_reg,  stage_repeats_next;
    logic                event_given_reg,    event_given_next;

    logic [COUNT_W-1:0]  wait_target;
    logic [COUNT_W-1:0]  repeat_target;
    logic [COUNT_W-1:0]  repeats_bumped;

    // Work out the next state for one poll tick
    always_comb
    begin
        settle_count_next  = settle_count_reg;
        wait_count_next    = wait_count_reg;
        stage_index_next   = stage_index_reg;
        stage_repeats_next = stage_repeats_reg;
        event_given_next   = event_given_reg;
        result.press_event = 1'b0;

        // Debounce: count while held high and steady, drop back to stage 0 on a change after an event
        if (level && (level == previous_level_reg))
        begin
            if (settle_count_reg < cfg.settle_limit)
            begin
                settle_count_next = settle_count_reg + 1'b1;
            end
        end
        else if ((level != previous_level_reg) && event_given_reg)
        begin
            event_given_next   = 1'b0;
            settle_count_next  = '0;
            stage_index_next   = '0;
            stage_repeats_next = '0;
        end
        previous_level_next = level;

        wait_target    = stage_byte(cfg.stage_wait_times, stage_index_next);
        repeat_target  = stage_byte(cfg.stage_repeat_counts, stage_index_next);
        repeats_bumped = (stage_repeats_next != COUNT_MAX) ? stage_repeats_next + 1'b1
                                                           : stage_repeats_next;

        // Threshold pass: fire a repeat or keep waiting
        if (settle_count_next > cfg.settle_threshold)
        begin
            settle_count_next = '0;
            if (wait_count_reg >= wait_target)
            begin
                stage_repeats_next = repeats_bumped;
                if ((stage_index_next < LAST_STAGE) && (repeats_bumped >= repeat_target))
                begin
                    stage_index_next   = stage_index_next + 1'b1;
                    stage_repeats_next = '0;
                end
                event_given_next   = 1'b1;
                wait_count_next    = '0;
                result.press_event = level;
            end
            else if (wait_count_reg != COUNT_MAX)
            begin
                wait_count_next = wait_count_reg + 1'b1;
            end
        end

        result.repeat_stage = stage_index_next;
    end

    // Advance the state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_level_reg <= 1'b0;
            settle_count_reg   <= '0;
            wait_count_reg     <= '0;
            stage_index_reg    <= '0;
            stage_repeats_reg  <= '0;
            event_given_reg    <= 1'b0;
        end
        else if (step)
        begin
            previous_level_reg <= previous_level_next;
            settle_count_reg   <= settle_count_next;
            wait_count_reg     <= wait_count_next;
            stage_index_reg    <= stage_index_next;
            stage_repeats_reg  <= stage_repeats_next;
            event_given_reg    <= event_given_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/key_autorepeat_accelerator.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    key_level
// out       output     out_valid / out_stall  press_event, repeat_stage
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock while in_stall is low: the state advances in the cycle the
// item is accepted and the result is registered into a two-entry output buffer.
// in_stall rises only when both buffer entries hold results not yet taken.
// cfg_ready is always high. Reset clears the state, empties the buffer and
// loads the register defaults.

module key_autorepeat_accelerator
    import kaa_pkg::*;
#(
    parameter int NUM_STAGES = DEFAULT_NUM_STAGES
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 key_level,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      press_event,
    output logic [STAGE_W-1:0]        repeat_stage,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PACKED_W-1:0]  cfg_data
);

    cfg_t        cfg_reg;
    result_t     result;
    result_t     slot0_reg, slot1_reg;
    logic [1:0]  fill_reg;
    logic        push, pop;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_threshold    <= SETTLE_THRESHOLD_RST;
            cfg_reg.settle_limit        <= SETTLE_LIMIT_RST;
            cfg_reg.stage_wait_times    <= STAGE_WAIT_RST;
            cfg_reg.stage_repeat_counts <= STAGE_REPEAT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SETTLE_THRESHOLD: cfg_reg.settle_threshold    <= cfg_data[SETTLE_W-1:0];
                REG_SETTLE_LIMIT:     cfg_reg.settle_limit        <= cfg_data[SETTLE_W-1:0];
                REG_STAGE_WAIT:       cfg_reg.stage_wait_times    <= cfg_data;
                REG_STAGE_REPEAT:     cfg_reg.stage_repeat_counts <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign in_stall  = (fill_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign out_valid = (fill_reg != 2'd0);
    assign pop       = out_valid && !out_stall;

    kaa_core #(
        .NUM_STAGES (NUM_STAGES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (push),
        .level  (key_level),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Track buffer fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            fill_reg <= fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_reg <= fill_reg - 2'd1;
        end
    end

    // Hold results in the output buffer, head in slot 0
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            slot0_reg <= (push && (fill_reg == 2'd1)) ? result : slot1_reg;
            if (push)
            begin
                slot1_reg <= result;
            end
        end
        else if (push)
        begin
            if (fill_reg == 2'd0)
            begin
                slot0_reg <= result;
            end
            else
            begin
                slot1_reg <= result;
            end
        end
    end

    assign press_event  = slot0_reg.press_event;
    assign repeat_stage = slot0_reg.repeat_stage;

endmodule

`default_nettype wire
